### rtl/mtd_pkg.sv
// Shared types, constants and the arctangent table for the transform decompose block.
// No dependencies.
package mtd_pkg;

  localparam int WORD_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int ANG_W    = 30;
  localparam int STEPS    = 30;
  localparam int ROT_W    = 19;
  localparam int NORM_W   = 18;
  localparam int NUM_W    = WORD_W + FRAC_W;
  localparam int XY_W     = 36;
  localparam int Z_W      = 35;
  localparam int TOL_W    = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  localparam logic signed [Z_W-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 35'sd1686629713;

  // shared unit operations
  typedef enum logic [1:0] {
    OP_SQRT = 2'd0,
    OP_DIV  = 2'd1,
    OP_ATAN = 2'd2
  } op_t;

  typedef struct packed {
    logic                     go;
    op_t                      op;
    logic [63:0]              rad;
    logic [NUM_W-1:0]         num;
    logic [WORD_W-1:0]        den;
    logic signed [NORM_W-1:0] cy;
    logic signed [NORM_W-1:0] cx;
  } iter_req_t;

  typedef struct packed {
    logic                    done;
    logic [WORD_W-1:0]       res;
    logic signed [ROT_W-1:0] ang;
  } iter_rsp_t;

  // atan(2^-i) in Q30
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h3243F6A8;  5'd1:  v = 32'h1DAC6705;  5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;  5'd4:  v = 32'h03FEAB76;  5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;  5'd7:  v = 32'h007FFF55;  5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;  5'd10: v = 32'h000FFFFF;  5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;  5'd13: v = 32'h0001FFFF;  5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;  5'd16: v = 32'h00003FFF;  5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;  5'd19: v = 32'h000007FF;  5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;  5'd22: v = 32'h000000FF;  5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;  5'd25: v = 32'h0000001F;  5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;  5'd28: v = 32'h00000004;  5'd29: v = 32'h00000002;
      default: v = 32'h0;
    endcase
    return Z_W'(signed'({1'b0, v}));
  endfunction

endpackage

### rtl/mtd_iter.sv
// Shared iterative unit: bitwise square root, restoring division, CORDIC arctangent.
// Depends on mtd_pkg.
module mtd_iter import mtd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  iter_req_t req,
  output iter_rsp_t rsp
);

  logic                    running;
  op_t                     op_r;
  logic [5:0]              cnt;
  logic [63:0]             v, r, bitm;
  logic [WORD_W-1:0]       rem, den_r;
  logic [NUM_W-1:0]        nq, qt;
  logic signed [XY_W-1:0]  x, y;
  logic signed [Z_W-1:0]   z;
  logic                    zero_ang;
  logic                    done;

  logic [64:0]             sq_t;
  logic                    sq_ge;
  logic [WORD_W:0]         remsh;
  logic                    d_ge;
  logic signed [XY_W-1:0]  xs, ys, dx, dy;
  logic signed [Z_W-1:0]   zc, zr;
  logic [5:0]              last;

  // one step of each operation
  assign sq_t  = {1'b0, r} + {1'b0, bitm};
  assign sq_ge = {1'b0, v} >= sq_t;
  assign remsh = {rem, nq[NUM_W-1]};
  assign d_ge  = remsh >= {1'b0, den_r};
  assign xs    = {{(XY_W-NORM_W-ANG_W+FRAC_W){req.cx[NORM_W-1]}}, req.cx,
                  {(ANG_W-FRAC_W){1'b0}}};
  assign ys    = {{(XY_W-NORM_W-ANG_W+FRAC_W){req.cy[NORM_W-1]}}, req.cy,
                  {(ANG_W-FRAC_W){1'b0}}};
  assign dx    = y >>> cnt[4:0];
  assign dy    = x >>> cnt[4:0];

  always_comb begin
    unique case (op_r)
      OP_SQRT: last = 6'd31;
      OP_DIV:  last = 6'(NUM_W - 1);
      default: last = 6'(STEPS - 1);
    endcase
  end

  // clamp to +-pi, round half up to signed Q3.16
  always_comb begin
    zc = z;
    if (z > PI_Q30) zc = PI_Q30;
    if (z < -PI_Q30) zc = -PI_Q30;
    zr = zc + Z_W'(1 << (ANG_W - FRAC_W - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        op_r     <= req.op;
        cnt      <= '0;
        zero_ang <= 1'b0;
        running  <= 1'b1;
        unique case (req.op)
          OP_SQRT: begin
            v    <= req.rad;
            r    <= '0;
            bitm <= 64'h4000_0000_0000_0000;
          end
          OP_DIV: begin
            rem   <= '0;
            nq    <= req.num;
            qt    <= '0;
            den_r <= req.den;
          end
          default: begin
            z <= '0;
            if (req.cx == '0 && req.cy == '0) begin
              zero_ang <= 1'b1;
              running  <= 1'b0;
              done     <= 1'b1;
            end else if (xs < 0) begin
              if (ys >= 0) begin
                x <= ys; y <= -xs; z <= HALF_PI_Q30;
              end else begin
                x <= -ys; y <= xs; z <= -HALF_PI_Q30;
              end
            end else begin
              x <= xs; y <= ys;
            end
          end
        endcase
      end else if (running) begin
        unique case (op_r)
          OP_SQRT: begin
            if (sq_ge) begin
              v <= v - sq_t[63:0];
              r <= (r >> 1) + bitm;
            end else begin
              r <= r >> 1;
            end
            bitm <= bitm >> 2;
          end
          OP_DIV: begin
            nq <= nq << 1;
            if (d_ge) begin
              rem <= WORD_W'(remsh - {1'b0, den_r});
              qt  <= {qt[NUM_W-2:0], 1'b1};
            end else begin
              rem <= remsh[WORD_W-1:0];
              qt  <= {qt[NUM_W-2:0], 1'b0};
            end
          end
          default: begin
            if (y >= 0) begin
              x <= x + dx; y <= y - dy; z <= z + atan_q30(cnt[4:0]);
            end else begin
              x <= x - dx; y <= y + dy; z <= z - atan_q30(cnt[4:0]);
            end
          end
        endcase
        cnt <= cnt + 6'd1;
        if (cnt == last) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.res  = (op_r == OP_SQRT) ? r[WORD_W-1:0] : qt[WORD_W-1:0];
  assign rsp.ang  = zero_ang ? '0 : zr[ANG_W-FRAC_W+ROT_W-1:ANG_W-FRAC_W];

endmodule

### rtl/matrix_transform_decompose_unit.sv
// Top level: column store, APB tolerance register and the decompose sequencer.
// Depends on mtd_pkg and mtd_iter.
//
// Columns 0..2 are taken one word per cycle, back to back, and busy stays low. A
// column-3 word whose |w| is under the tolerance gives its result on done the next
// cycle. Otherwise the block goes busy. Per stored column it squares the elements,
// takes a root (32 steps) and does three divisions (48 steps); a zero-length column
// skips its divisions. Then come the sine term, a root and two or three CORDIC
// passes (30 steps), two in the gimbal case. The roots, divisions and passes all run
// on one shared iterative unit. done is high for exactly one cycle per result, in the
// first cycle after busy drops, and cannot be held off; results must be taken then.
module matrix_transform_decompose_unit import mtd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                column_index,
  input  logic signed [WORD_W-1:0]  elem_x,
  input  logic signed [WORD_W-1:0]  elem_y,
  input  logic signed [WORD_W-1:0]  elem_z,
  input  logic signed [WORD_W-1:0]  elem_w,
  output logic                      done,
  output logic                      ok,
  output logic signed [WORD_W-1:0]  trans_x,
  output logic signed [WORD_W-1:0]  trans_y,
  output logic signed [WORD_W-1:0]  trans_z,
  output logic signed [ROT_W-1:0]   rot_x,
  output logic signed [ROT_W-1:0]   rot_y,
  output logic signed [ROT_W-1:0]   rot_z,
  output logic [WORD_W-2:0]         scale_x,
  output logic [WORD_W-2:0]         scale_y,
  output logic [WORD_W-2:0]         scale_z,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [1:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQR  = 7'b0000010,
    S_LEN  = 7'b0000100,
    S_NORM = 7'b0001000,
    S_SIN  = 7'b0010000,
    S_ROOT = 7'b0100000,
    S_ANG  = 7'b1000000
  } state_t;

  state_t                   state;
  logic [TOL_W-1:0]         tol;
  logic signed [WORD_W-1:0] cols [9];
  logic signed [NORM_W-1:0] nv [9];
  logic [1:0]               k, j;
  logic [63:0]              acc, prod;
  logic [WORD_W-1:0]        len_r;
  logic signed [NORM_W-1:0] s_r, cy_r, cx_r;
  logic                     gimbal;
  logic                     go;
  op_t                      op_r;
  iter_req_t                req;
  iter_rsp_t                rsp;

  logic                     accept;
  logic [3:0]               idx;
  logic signed [WORD_W-1:0] csel;
  logic [WORD_W-1:0]        msel, wmag;
  logic                     nd;
  logic signed [NORM_W-1:0] qv;
  logic signed [2*NORM_W-1:0] ssq;

  localparam logic signed [NORM_W-1:0] ONE = NORM_W'(1 << FRAC_W);

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;
  assign prdata = {16'b0, tol};

  // stored element for the current column and row
  assign idx  = 4'(k) * 4'd3 + 4'(j);
  assign csel = cols[idx];
  assign msel = csel[WORD_W-1] ? WORD_W'(-csel) : WORD_W'(csel);
  assign wmag = elem_w[WORD_W-1] ? WORD_W'(-elem_w) : WORD_W'(elem_w);
  assign ssq  = s_r * s_r;

  // normalize step: zero-length column gives zero without using the unit
  assign nd = (len_r == '0) ? 1'b1 : rsp.done;
  assign qv = (len_r == '0) ? '0 :
              (csel[WORD_W-1] ? -NORM_W'(rsp.res[FRAC_W:0]) : NORM_W'(rsp.res[FRAC_W:0]));

  assign req.go  = go;
  assign req.op  = op_r;
  assign req.rad = acc;
  assign req.num = {msel, {FRAC_W{1'b0}}};
  assign req.den = len_r;
  assign req.cy  = cy_r;
  assign req.cx  = cx_r;

  mtd_iter u_iter (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      tol <= pwdata[TOL_W-1:0];
    end
  end

  // column store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) cols[i] <= '0;
    end else if (accept && column_index != 2'd3) begin
      cols[4'(column_index) * 4'd3]        <= elem_x;
      cols[4'(column_index) * 4'd3 + 4'd1] <= elem_y;
      cols[4'(column_index) * 4'd3 + 4'd2] <= elem_z;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      go    <= 1'b0;
      done  <= 1'b0;
    end else begin
      go   <= 1'b0;
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && column_index == 2'd3) begin
            rot_x <= '0; rot_y <= '0; rot_z <= '0;
            scale_x <= '0; scale_y <= '0; scale_z <= '0;
            if (wmag < {16'b0, tol}) begin
              ok <= 1'b0; trans_x <= '0; trans_y <= '0; trans_z <= '0;
              done <= 1'b1;
            end else begin
              ok <= 1'b1; trans_x <= elem_x; trans_y <= elem_y; trans_z <= elem_z;
              k <= '0; j <= '0; acc <= '0; prod <= '0;
              state <= S_SQR;
            end
          end
        end
        S_SQR: begin
          acc <= acc + prod;
          if (j != 2'd3) begin
            prod <= 64'(msel) * 64'(msel);
            j    <= j + 2'd1;
          end else begin
            op_r  <= OP_SQRT;
            go    <= 1'b1;
            state <= S_LEN;
          end
        end
        S_LEN: begin
          if (rsp.done) begin
            len_r <= rsp.res;
            unique case (k)
              2'd0:    scale_x <= rsp.res[WORD_W-1] ? '1 : rsp.res[WORD_W-2:0];
              2'd1:    scale_y <= rsp.res[WORD_W-1] ? '1 : rsp.res[WORD_W-2:0];
              default: scale_z <= rsp.res[WORD_W-1] ? '1 : rsp.res[WORD_W-2:0];
            endcase
            j     <= '0;
            op_r  <= OP_DIV;
            go    <= (rsp.res != '0);
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (nd) begin
            nv[idx] <= qv;
            if (j != 2'd2) begin
              j  <= j + 2'd1;
              go <= (len_r != '0);
            end else if (k != 2'd2) begin
              k <= k + 2'd1; j <= '0; acc <= '0; prod <= '0;
              state <= S_SQR;
            end else begin
              j <= '0;
              state <= S_SIN;
            end
          end
        end
        S_SIN: begin
          // s = -n0.z, then 1 - s*s in Q32
          unique case (j)
            2'd0: begin
              s_r <= -nv[2];
              j   <= 2'd1;
            end
            2'd1: begin
              prod <= 64'(ssq);
              j    <= 2'd2;
            end
            default: begin
              acc   <= 64'h1_0000_0000 - prod;
              op_r  <= OP_SQRT;
              go    <= 1'b1;
              state <= S_ROOT;
            end
          endcase
        end
        S_ROOT: begin
          if (rsp.done) begin
            cy_r   <= s_r;
            cx_r   <= NORM_W'(rsp.res[FRAC_W:0]);
            gimbal <= (s_r == ONE) || (s_r == -ONE);
            j      <= '0;
            op_r   <= OP_ATAN;
            go     <= 1'b1;
            state  <= S_ANG;
          end
        end
        S_ANG: begin
          if (rsp.done) begin
            unique case (j)
              2'd0: begin
                rot_y <= rsp.ang;
                cy_r  <= gimbal ? -nv[6] : nv[5];
                cx_r  <= gimbal ? nv[4] : nv[8];
                j     <= 2'd1;
                go    <= 1'b1;
              end
              2'd1: begin
                rot_x <= rsp.ang;
                if (gimbal) begin
                  done  <= 1'b1;
                  state <= S_IDLE;
                end else begin
                  cy_r <= nv[1];
                  cx_r <= nv[0];
                  j    <= 2'd2;
                  go   <= 1'b1;
                end
              end
              default: begin
                rot_z <= rsp.ang;
                done  <= 1'b1;
                state <= S_IDLE;
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/mtd_checker.sv
// Port-level checks for the transform decompose block, bound to the top level.
// Depends on mtd_pkg.
module mtd_checker import mtd_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic [1:0]               column_index,
  input logic                     done,
  input logic                     ok,
  input logic signed [WORD_W-1:0] trans_x,
  input logic signed [ROT_W-1:0]  rot_x,
  input logic signed [ROT_W-1:0]  rot_y,
  input logic [WORD_W-2:0]        scale_x
);

  // a word out needs a column-3 word in or work under way
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || ($past(start) && $past(column_index) == 2'd3))
    else $error("result without a triggering column");

  // work starts only from an accepted column 3
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start) && $past(column_index) == 2'd3)
    else $error("busy without column 3");

  // a rejected matrix reports zeros
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    done && !ok |-> trans_x == '0 && rot_x == '0 && scale_x == '0)
    else $error("rejected result not zero");

  // rot_x and rot_y stay within +-pi
  a_ang_range: assert property (@(posedge clk) disable iff (rst)
    done |-> rot_x <= 19'sd205888 && rot_x >= -19'sd205888 &&
             rot_y <= 19'sd205888 && rot_y >= -19'sd205888)
    else $error("angle out of range");

endmodule

bind matrix_transform_decompose_unit mtd_checker u_mtd_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .column_index (column_index),
  .done         (done),
  .ok           (ok),
  .trans_x      (trans_x),
  .rot_x        (rot_x),
  .rot_y        (rot_y),
  .scale_x      (scale_x)
);

### dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for matrix_transform_decompose_unit: drives matrix columns and the tolerance
// register, predicts each decompose result and checks it. Depends on mtd_pkg and the RTL.
module testbench;
  import mtd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 900;
  localparam logic [1:0] TOL_ADDR = 2'd0;

  typedef struct {
    logic [1:0]         col;
    logic signed [31:0] x, y, z, w;
  } column_word_t;

  typedef struct {
    logic               ok;
    logic signed [31:0] tx, ty, tz;
    logic signed [18:0] rx, ry, rz;
    logic [30:0]        sx, sy, sz;
  } pose_t;

  // Predicts pose words from column words and checks them in order
  class decompose_scoreboard;
    longint cols[9];
    longint unsigned tol = 1;
    pose_t  pending[$];
    int     errors, results, invalid;
    longint atan_tab[30] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
      'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
      'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
      'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
      'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002};

    function longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // CORDIC vectoring in Q30, result rounded to Q3.16
    function longint cordic_atan2(longint y, longint x);
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * (64'sd1 << 14);
      y = y * (64'sd1 << 14);
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; z = HALF_PI_Q30;
        end else begin
          x = -y; y = t; z = -HALF_PI_Q30;
        end
      end
      for (int i = 0; i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += atan_tab[i];
        end else begin
          x -= dx; y += dy; z -= atan_tab[i];
        end
      end
      if (z > PI_Q30) z = PI_Q30;
      if (z < -PI_Q30) z = -PI_Q30;
      return (z + (64'sd1 << 13)) >>> 14;
    endfunction

    function void note_column(column_word_t cw);
      pose_t p;
      longint n[3][3];
      longint unsigned sq, len, q, scl[3];
      longint one, s, rx, ry, rz;
      one = 64'sd1 << FRAC_W;
      if (cw.col != 2'd3) begin
        cols[cw.col*3]   = cw.x;
        cols[cw.col*3+1] = cw.y;
        cols[cw.col*3+2] = cw.z;
        return;
      end
      p = '{default: '0};
      if (magnitude(cw.w) < tol) begin
        invalid++;
        pending.push_back(p);
        return;
      end
      for (int k = 0; k < 3; k++) begin
        sq = 0;
        for (int j = 0; j < 3; j++) sq += magnitude(cols[k*3+j]) * magnitude(cols[k*3+j]);
        len = floor_sqrt(sq);
        scl[k] = (len > 64'h7FFFFFFF) ? 64'h7FFFFFFF : len;
        for (int j = 0; j < 3; j++) begin
          q = (len != 0) ? (magnitude(cols[k*3+j]) << FRAC_W) / len : 0;
          n[k][j] = (cols[k*3+j] < 0) ? -longint'(q) : longint'(q);
        end
      end
      s = -n[0][2];
      if (s > one) s = one;
      if (s < -one) s = -one;
      ry = cordic_atan2(s, longint'(floor_sqrt(longint'(one * one - s * s))));
      // gimbal lock: rotation folded into rx
      if (s == one || s == -one) begin
        rx = cordic_atan2(-n[2][0], n[1][1]);
        rz = 0;
      end else begin
        rx = cordic_atan2(n[1][2], n[2][2]);
        rz = cordic_atan2(n[0][1], n[0][0]);
      end
      p.ok = 1'b1;
      p.tx = cw.x; p.ty = cw.y; p.tz = cw.z;
      p.rx = rx[18:0]; p.ry = ry[18:0]; p.rz = rz[18:0];
      p.sx = scl[0][30:0]; p.sy = scl[1][30:0]; p.sz = scl[2][30:0];
      pending.push_back(p);
    endfunction

    function bit field_ok(string name, longint e, longint a);
      if (e == a) return 1'b1;
      errors++;
      if (errors <= 10)
        $display("%0t: mismatch %s expected %0h got %0h", $time, name, e, a);
      return 1'b0;
    endfunction

    function void check_pose(pose_t a);
      pose_t e;
      bit good;
      results++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: unexpected result word", $time);
        return;
      end
      e = pending.pop_front();
      good = field_ok("ok", e.ok, a.ok);
      good &= field_ok("trans_x", e.tx, a.tx);
      good &= field_ok("trans_y", e.ty, a.ty);
      good &= field_ok("trans_z", e.tz, a.tz);
      good &= field_ok("rot_x", e.rx, a.rx);
      good &= field_ok("rot_y", e.ry, a.ry);
      good &= field_ok("rot_z", e.rz, a.rz);
      good &= field_ok("scale_x", e.sx, a.sx);
      good &= field_ok("scale_y", e.sy, a.sy);
      good &= field_ok("scale_z", e.sz, a.sz);
    endfunction
  endclass

  logic clk = 0, rst = 1, start = 0;
  logic [1:0] column_index = '0;
  logic signed [31:0] elem_x = '0, elem_y = '0, elem_z = '0, elem_w = '0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic busy, done, ok, pready;
  logic signed [31:0] trans_x, trans_y, trans_z;
  logic signed [18:0] rot_x, rot_y, rot_z;
  logic [30:0] scale_x, scale_y, scale_z;

  decompose_scoreboard sb = new;
  int words_sent, idle_cycles, burst_left;

  matrix_transform_decompose_unit dut (.*);

  initial forever #6 clk = ~clk;

  // Monitor: accepted column words and result strobes
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (start && !busy)
        sb.note_column('{column_index, elem_x, elem_y, elem_z, elem_w});
      if (done)
        sb.check_pose('{ok, trans_x, trans_y, trans_z, rot_x, rot_y, rot_z,
                        scale_x, scale_y, scale_z});
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Send one column word; bursts keep start high, gaps drop it
  task automatic send_column(logic [1:0] c, logic signed [31:0] x, y, z, w);
    start <= 1'b1;
    column_index <= c;
    elem_x <= x; elem_y <= y; elem_z <= z; elem_w <= w;
    do @(posedge clk); while (busy);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [15:0] v);
    drain_results();
    repeat (20) @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= TOL_ADDR; pwdata <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.tol = v;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_elem();
    int unsigned sel;
    sel = $urandom_range(0, 15);
    if (sel < 5) return $urandom;
    if (sel < 13) return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    if (sel == 13) return 0;
    case ($urandom_range(0, 3))
      0: return 32'sh80000000;
      1: return 32'sh7FFFFFFF;
      2: return 32'sh00010000;
      default: return -32'sh00010000;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_w();
    if ($urandom_range(0, 3) == 0)
      return 32'($signed($urandom_range(0, 2 * sb.tol + 4)) - $signed(sb.tol + 2));
    return ($urandom_range(0, 1) == 0) ? 32'sh00010000 : $urandom;
  endfunction

  // Mostly full matrices in order, some stray columns
  task automatic random_items(int count);
    logic signed [31:0] k;
    int n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 7) == 0) begin
        send_column(2'($urandom_range(0, 3)), pick_elem(), pick_elem(), pick_elem(),
                    pick_elem());
        n++;
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          k = $urandom_range(1, 1 << 20);
          send_column(2'd0, 0, 0, ($urandom_range(0, 1) ? k : -k), pick_elem());
        end else begin
          send_column(2'd0, pick_elem(), pick_elem(), pick_elem(), pick_elem());
        end
        send_column(2'd1, pick_elem(), pick_elem(), pick_elem(), pick_elem());
        send_column(2'd2, pick_elem(), pick_elem(), pick_elem(), pick_elem());
        send_column(2'd3, pick_elem(), pick_elem(), pick_elem(), pick_w());
        n += 4;
      end
      // occasionally hold off until all results are back
      if ($urandom_range(0, 40) == 0) drain_results();
    end
  endtask

  initial begin
    logic [15:0] tol_steps[5];
    tol_steps = '{16'd0, 16'hFFFF, 16'd0, 16'd300, 16'd1};
    tol_steps[2] = 16'($urandom_range(2, 65534));
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: result before any column, identity, near-zero w, extremes, gimbal
    send_column(2'd3, 32'sh12345678, -32'sh1, 32'sh7FFFFFFF, 32'sh00010000);
    send_column(2'd0, 32'sh00010000, 0, 0, 0);
    send_column(2'd1, 0, 32'sh00010000, 0, 0);
    send_column(2'd2, 0, 0, 32'sh00010000, 0);
    send_column(2'd3, 32'sh80000000, 32'sh7FFFFFFF, 0, 32'sh00010000);
    send_column(2'd3, 1, 2, 3, 0);
    send_column(2'd3, 1, 2, 3, 32'sh80000000);
    send_column(2'd0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_column(2'd1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_column(2'd2, 0, 0, 0, -1);
    send_column(2'd3, 32'sh7FFFFFFF, 32'sh80000000, -1, -1);
    send_column(2'd0, 0, 0, -32'sh00020000, 0);
    send_column(2'd1, 0, 32'sh00010000, 0, 0);
    send_column(2'd2, 32'sh00010000, 0, 0, 0);
    send_column(2'd3, 0, 0, 0, 32'sh7FFFFFFF);
    send_column(2'd0, 0, 0, 32'sh00010000, 0);
    send_column(2'd3, 0, 0, 0, 1);
    send_column(2'd0, -32'sh00010000, -32'sh00010000, 0, 0);
    send_column(2'd3, 0, 0, 0, -1);

    foreach (tol_steps[i]) begin
      write_tolerance(tol_steps[i]);
      random_items(165);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0) sb.errors++;
    $display("Sent %0d column words over %0d tolerance settings; %0d results, %0d invalid.",
             words_sent, 6, sb.results, sb.invalid);
    $display("Mismatches: %0d", sb.errors);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
